[hdl/iepmp_pkg.sv]
// Shared constants, widths and the controller-to-datapath command type.
package iepmp_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int PRICE_W   = 16;
    localparam int TOTAL_W   = 28;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int PROD_W    = PRICE_W + CNT_W;
    // bound: max price times the sum of days 1..MAX_ITEMS
    localparam int BEST_W    = PRICE_W + $clog2(MAX_ITEMS * (MAX_ITEMS + 1) / 2 + 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic              load_en;
        logic [IDX_W-1:0]  load_addr;
        logic              issue;
        logic              init;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  jdx;
        logic [CNT_W-1:0]  day;
        logic              capture;
    } dp_cmd_t;

endpackage

[hdl/iepmp_ram.sv]
// Generic single write port, single read port RAM with registered read.
module iepmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/iepmp_ctrl.sv]
// Sequencer: row loading, interval-length passes and result hand-off.
module iepmp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               overflowed,
    output iepmp_pkg::dp_cmd_t cmd
);
    import iepmp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             row_ovf_reg, row_ovf_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic             drain_reg, drain_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             in_req;
    logic             room;
    logic [CNT_W-1:0] last_i;
    logic             capture;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_req   = in_valid && in_ready;
    assign room     = (count_reg < CNT_W'(MAX_ITEMS));
    assign last_i   = n_reg - len_reg;
    assign capture  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.load_en   = in_req && room;
        cmd.load_addr = count_reg[IDX_W-1:0];
        cmd.issue     = (state_reg == ST_RUN);
        cmd.init      = (len_reg == CNT_W'(1));
        cmd.idx       = i_reg;
        cmd.jdx       = IDX_W'(CNT_W'(i_reg) + len_reg - CNT_W'(1));
        cmd.day       = n_reg - len_reg + CNT_W'(1);
        cmd.capture   = capture;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        row_ovf_next   = row_ovf_reg;
        n_next         = n_reg;
        len_next       = len_reg;
        i_next         = i_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        n_next       = room ? count_reg + CNT_W'(1) : count_reg;
                        row_ovf_next = ovf_reg || !room;
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        len_next     = CNT_W'(1);
                        i_next       = '0;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (CNT_W'(i_reg) == last_i)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // wait for drain_reg so the last write lands before the next pass reads
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    if (len_reg == n_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        len_next   = len_reg + CNT_W'(1);
                        i_next     = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_FINISH:
            begin
                if (capture)
                begin
                    out_valid_next = 1'b1;
                    out_ovf_next   = row_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            row_ovf_reg   <= 1'b0;
            n_reg         <= '0;
            len_reg       <= '0;
            i_reg         <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            row_ovf_reg   <= row_ovf_next;
            n_reg         <= n_next;
            len_reg       <= len_next;
            i_reg         <= i_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign overflowed = out_ovf_reg;

endmodule

[hdl/iepmp_dp.sv]
// Datapath: price and best-row RAMs, pipelined take-left/take-right step.
module iepmp_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  iepmp_pkg::dp_cmd_t              cmd,
    input  logic [iepmp_pkg::PRICE_W-1:0]   price,
    output logic [iepmp_pkg::TOTAL_W-1:0]   best_total
);
    import iepmp_pkg::*;

    localparam int EXT_W = (BEST_W > TOTAL_W) ? BEST_W : TOTAL_W;

    logic [PRICE_W-1:0] pa_rd, pb_rd;
    logic [BEST_W-1:0]  best_rd;
    logic               best_we;
    logic [IDX_W-1:0]   best_waddr;
    logic [BEST_W-1:0]  best_wdata;

    // stage 1: RAM data returns
    logic               s1_valid_reg;
    logic               s1_init_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [CNT_W-1:0]   s1_day_reg;
    logic [BEST_W-1:0]  carry_reg;

    // stage 2: products registered, add and compare
    logic               s2_valid_reg;
    logic               s2_init_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [PROD_W-1:0]  prod_l_reg, prod_r_reg;
    logic [BEST_W-1:0]  bnext_reg, bcur_reg;

    logic [BEST_W-1:0]  first_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [BEST_W-1:0]  bcur;
    logic [BEST_W-1:0]  sum_l, sum_r;

    iepmp_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_ITEMS)) u_price_a (
        .clk     (clk),
        .wr_en   (cmd.load_en),
        .wr_addr (cmd.load_addr),
        .wr_data (price),
        .rd_addr (cmd.idx),
        .rd_data (pa_rd)
    );

    // second copy so both ends of the interval read in the same cycle
    iepmp_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_ITEMS)) u_price_b (
        .clk     (clk),
        .wr_en   (cmd.load_en),
        .wr_addr (cmd.load_addr),
        .wr_data (price),
        .rd_addr (cmd.jdx),
        .rd_data (pb_rd)
    );

    iepmp_ram #(.WIDTH(BEST_W), .DEPTH(MAX_ITEMS)) u_best (
        .clk     (clk),
        .wr_en   (best_we),
        .wr_addr (best_waddr),
        .wr_data (best_wdata),
        .rd_addr (cmd.idx + IDX_W'(1)),
        .rd_data (best_rd)
    );

    // old best[i] is last step's best[i+1]; at the start of a pass it is best[0]
    assign bcur = (s1_idx_reg == '0) ? first_reg : carry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_init_reg <= cmd.init;
        s1_idx_reg  <= cmd.idx;
        s1_day_reg  <= cmd.day;
        if (s1_valid_reg)
        begin
            carry_reg <= best_rd;
        end
        s2_init_reg <= s1_init_reg;
        s2_idx_reg  <= s1_idx_reg;
        prod_l_reg  <= PROD_W'(pa_rd) * PROD_W'(s1_day_reg);
        prod_r_reg  <= PROD_W'(pb_rd) * PROD_W'(s1_day_reg);
        bnext_reg   <= best_rd;
        bcur_reg    <= bcur;
        if (best_we && (s2_idx_reg == '0))
        begin
            first_reg <= best_wdata;
        end
        if (cmd.capture)
        begin
            total_reg <= (EXT_W'(first_reg) > EXT_W'(TOTAL_MAX)) ?
                         TOTAL_MAX : TOTAL_W'(first_reg);
        end
    end

    assign sum_l      = BEST_W'(prod_l_reg) + bnext_reg;
    assign sum_r      = BEST_W'(prod_r_reg) + bcur_reg;
    assign best_we    = s2_valid_reg;
    assign best_waddr = s2_idx_reg;
    assign best_wdata = s2_init_reg ? BEST_W'(prod_l_reg) :
                        ((sum_l > sum_r) ? sum_l : sum_r);
    assign best_total = total_reg;

endmodule

[hdl/interval_end_pick_max_profit_top.sv]
// Top level: interval end-pick maximum profit solver.
// Prices are loaded one request per cycle while idle (up to 64 stored;
// further items are dropped and reported through overflowed). The request
// carrying last starts the solve: a first pass seeds the best row, then one
// pass runs per interval length 2..n, every pass followed by the drain
// state so the best-row RAM write settles. Within a pass the single
// take-left/take-right step runs once per cycle against the best-row RAM.
// No input is taken during a solve; the result sits in an output register
// and a new row may load while it waits.
module interval_end_pick_max_profit_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [iepmp_pkg::PRICE_W-1:0] price,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iepmp_pkg::TOTAL_W-1:0] best_total,
    output logic                          overflowed
);
    import iepmp_pkg::*;

    dp_cmd_t cmd;

    iepmp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .overflowed (overflowed),
        .cmd        (cmd)
    );

    iepmp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .price      (price),
        .best_total (best_total)
    );

endmodule
